FILE: sv/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SEXTET_W = 6;
	localparam int unsigned GRP_CHARS = 4;
	localparam int unsigned IDX_W    = $clog2(GRP_CHARS);
	localparam int unsigned PAD_W    = 2;

	// group queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

	// one finished group: four sextets, how many trailing pads, end of message
	typedef struct packed {
		logic [GRP_CHARS-1:0][SEXTET_W-1:0] sextet;
		logic [PAD_W-1:0]                   pad;
		logic                               last;
	} grp_t;

	// queue write side
	typedef struct packed {
		logic push;
		grp_t grp;
	} grp_push_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [BYTE_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
		logic [BYTE_W-1:0] w;
		logic [BYTE_W-1:0] c;
		w = {2'b00, v};
		if (v < 6'd26) begin
			c = 8'h41 + w;
		end else if (v < 6'd52) begin
			c = 8'h61 + (w - 8'd26);
		end else if (v < 6'd62) begin
			c = 8'h30 + (w - 8'd52);
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: sv/b64e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, holds a partial group and packs finished groups into sextets.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              q_full,
	output grp_push_t              q_wr
);

	logic [BYTE_W-1:0] held_first_q;
	logic [BYTE_W-1:0] held_second_q;
	logic [1:0]        held_count_q;
	logic              accept;
	logic              emit;
	grp_t              grp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign emit     = in_last || held_count_q[1];

	always_comb begin
		grp        = '0;
		grp.last   = in_last;
		unique case (held_count_q)
			2'd0: begin
				grp.sextet[0] = in_byte[7:2];
				grp.sextet[1] = {in_byte[1:0], 4'b0000};
				grp.pad       = 2'd2;
			end
			2'd1: begin
				grp.sextet[0] = held_first_q[7:2];
				grp.sextet[1] = {held_first_q[1:0], in_byte[7:4]};
				grp.sextet[2] = {in_byte[3:0], 2'b00};
				grp.pad       = 2'd1;
			end
			2'd2, 2'd3: begin
				grp.sextet[0] = held_first_q[7:2];
				grp.sextet[1] = {held_first_q[1:0], held_second_q[7:4]};
				grp.sextet[2] = {held_second_q[3:0], in_byte[7:6]};
				grp.sextet[3] = in_byte[5:0];
				grp.pad       = 2'd0;
			end
		endcase
	end

	assign q_wr.push = accept && emit;
	assign q_wr.grp  = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_first_q  <= '0;
			held_second_q <= '0;
			held_count_q  <= '0;
		end else if (accept) begin
			if (emit) begin
				// drop pending state once a group leaves
				held_first_q  <= '0;
				held_second_q <= '0;
				held_count_q  <= '0;
			end else if (held_count_q == 2'd0) begin
				held_first_q <= in_byte;
				held_count_q <= 2'd1;
			end else begin
				held_second_q <= in_byte;
				held_count_q  <= 2'd2;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/b64e_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue that decouples the byte side from the character side.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire grp_push_t wr,
	output logic           full,
	input  wire logic      pop,
	output logic           empty,
	output grp_t           head
);

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr.push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/b64e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head group one character per cycle, unless stalled, into a registered output.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire grp_t       q_head,
	output logic            q_pop,
	output logic [BYTE_W-1:0] out_char,
	output logic            out_last,
	output logic            out_valid,
	input  wire logic       out_stall
);

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              out_last_q;
	logic              load;
	logic              take;
	logic              is_pad;
	logic              final_char;
	logic [BYTE_W-1:0] next_char;

	assign load       = !out_valid_q || !out_stall;
	assign take       = load && !q_empty;
	assign final_char = (idx_q == IDX_W'(GRP_CHARS - 1));
	assign q_pop      = take && final_char;
	assign is_pad     = ({1'b0, idx_q} + {1'b0, q_head.pad}) >= 3'(GRP_CHARS);
	assign next_char  = is_pad ? PAD_CHAR : sextet_char(q_head.sextet[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			idx_q       <= idx_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (load) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= next_char;
			out_last_q <= q_head.last && final_char;
		end
	end

	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: sv/base64_stream_encoder.sv
`default_nettype none
// Path: a finished group enters the group queue, then each of its characters is
//   registered in the output register, one per cycle while the output is not stalled.
// Throughput: one byte per cycle in unless the queue is full, one character per cycle out
//   unless out_stall; three bytes give four characters, so the character port sets the sustained rate.
// The two-entry group queue absorbs stalls on either side independently.
// Reset: arst_n clears pending bytes, queue pointers and the output valid at once.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64e_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic [BYTE_W-1:0]      out_char,
	output logic                   out_last,
	output logic                   out_valid,
	input  wire logic              out_stall
);

	// front to queue: a finished group plus its push strobe
	grp_push_t q_wr;
	logic      q_full;
	// queue to back: head group and pop when its last character is taken
	logic      q_empty;
	logic      q_pop;
	grp_t      q_head;

	// Front: hold up to two bytes per word stream, pack a group on the third
	// byte or on the last byte of a message. Stall only when the queue is full.
	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	// Queue: two groups deep so the front keeps taking words while the back
	// drains the previous group.
	b64e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	// Back: advance through the four characters of the head group, map each
	// sextet through the alphabet or substitute padding, and hold the output
	// register while the consumer stalls.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_char  (out_char),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming base64 encoder character by character. A short table
// covers the alphabet ends, every group length and padding. Random messages
// follow, with stalls on both ports and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench import b64e_pkg::*; ();

	// give up well past the slowest legal run: ~370 words, four characters each,
	// every character behind a stalled output, plus the hold-off stretch
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned IDLE_PCT = 35;
	localparam int unsigned REPORT_MAX = 10;

	localparam logic [0:63][BYTE_W-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// one expected character on the output port
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              last;
	} glyph_t;

	// one directed word; typed rows carry the four characters by hand
	typedef struct packed {
		logic [BYTE_W-1:0]            data;
		logic                         last;
		logic                         typed;
		logic [0:3][BYTE_W-1:0]       chars;
	} demo_row_t;

	localparam int DEMO_N = 22;
	localparam demo_row_t DEMO_ROWS [0:DEMO_N-1] = '{
		// lone byte at both extremes: two characters and two pads
		'{8'h00, 1'b1, 1'b1, "AA=="},
		'{8'hFF, 1'b1, 1'b1, "/w=="},
		// full group closed by the last word
		'{8'h4D, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b0, 1'b0, 32'h0},
		'{8'h6E, 1'b1, 1'b1, "TWFu"},
		// two-byte message: one pad
		'{8'h4D, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b1, 1'b1, "TWE="},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, "//8="},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b1, 1'b1, "AAA="},
		// full group in mid-message with no end mark, then one closed by the last word
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b1, "////"},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b1, 1'b1, "AAAA"},
		// top two alphabet entries
		'{8'hFB, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hBF, 1'b1, 1'b1, "+/+/"},
		'{8'h80, 1'b0, 1'b0, 32'h0},
		'{8'h01, 1'b1, 1'b0, 32'h0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              in_last = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] out_char;
	logic              out_last;
	logic              out_valid;
	logic              out_stall = 1'b0;

	// phase controls owned by the stimulus process
	logic calm = 1'b0;
	logic hold_token = 1'b0;

	// receiver side hold-off bookkeeping
	logic hold_seen = 1'b0;
	int unsigned hold_left = 0;

	// encoder state mirror
	logic [BYTE_W-1:0] held_a = '0;
	logic [BYTE_W-1:0] held_b = '0;
	logic [1:0]        held_n = '0;

	glyph_t pending_glyphs [$];
	int unsigned fail_count = 0;
	int unsigned cycles = 0;

	base64_stream_encoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_char (out_char),
		.out_last (out_last),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	always #1 clk = ~clk;

	function automatic logic [BYTE_W-1:0] alphabet_char(input logic [5:0] v);
		return ALPHABET[v];
	endfunction

	// Advance the mirrored state by one word; return how many characters
	// it releases (zero or four), pads filled in by default.
	function automatic int encode_word(input logic [BYTE_W-1:0] data, input logic last,
			output logic [0:3][BYTE_W-1:0] chars);
		int n;
		n = 0;
		chars = {4{PAD_CHAR}};
		unique case (held_n)
			2'd0: begin
				if (!last) begin
					held_a = data;
					held_n = 2'd1;
				end else begin
					chars[0] = alphabet_char(data[7:2]);
					chars[1] = alphabet_char({data[1:0], 4'b0000});
					n = 4;
				end
			end
			2'd1: begin
				if (!last) begin
					held_b = data;
					held_n = 2'd2;
				end else begin
					chars[0] = alphabet_char(held_a[7:2]);
					chars[1] = alphabet_char({held_a[1:0], data[7:4]});
					chars[2] = alphabet_char({data[3:0], 2'b00});
					n = 4;
				end
			end
			default: begin
				// third byte closes the group, whatever the end mark says
				chars[0] = alphabet_char(held_a[7:2]);
				chars[1] = alphabet_char({held_a[1:0], held_b[7:4]});
				chars[2] = alphabet_char({held_b[3:0], data[7:6]});
				chars[3] = alphabet_char(data[5:0]);
				n = 4;
			end
		endcase
		if (n != 0) begin
			held_a = '0;
			held_b = '0;
			held_n = '0;
		end
		return n;
	endfunction

	// Offer one word, hold it until accepted, then queue its characters.
	// Called right after a rising edge; returns right after the accepting edge.
	task automatic send_word(input logic [BYTE_W-1:0] data, input logic last,
			input logic typed, input logic [0:3][BYTE_W-1:0] typed_chars);
		logic [0:3][BYTE_W-1:0] chars;
		int n;
		glyph_t g;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_byte  <= data;
		in_last  <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n = encode_word(data, last, chars);
		// typed rows override the mirror but still advance it
		if (typed)
			chars = typed_chars;
		for (int k = 0; k < n; k++) begin
			g.ch   = chars[k];
			g.last = (k == 3) ? last : 1'b0;
			pending_glyphs.insert(pending_glyphs.size(), g);
		end
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Send whole messages until the word budget is used up; mostly short
	// ones so every group length and pad count shows up often.
	task automatic send_messages(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
			for (int k = 0; k < len; k++)
				send_word(pick_byte(), k == len - 1, 1'b0, '0);
			sent += len;
		end
	endtask

	task automatic check_glyph(input logic [BYTE_W-1:0] ch, input logic last);
		glyph_t want;
		if (pending_glyphs.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("unexpected character: char=%h last=%b", ch, last);
		end else begin
			want = pending_glyphs.pop_front();
			if (want.ch !== ch || want.last !== last) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("mismatch: expected char=%h last=%b, got char=%h last=%b",
						want.ch, want.last, ch, last);
			end
		end
	endtask

	// Output side: check each accepted character, then pick the next stall.
	// A toggle of hold_token starts a long hold-off that fills the block.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_glyph(out_char, out_last);
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: drop out if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// hold reset, then release it on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DEMO_N; i++)
			send_word(DEMO_ROWS[i].data, DEMO_ROWS[i].last, DEMO_ROWS[i].typed,
				DEMO_ROWS[i].chars);

		// random messages with idling on both sides
		send_messages(110);

		// stretch with no idling at all
		calm <= 1'b1;
		send_messages(60);

		// hold off the output while words keep coming, so the block backs up
		hold_token <= ~hold_token;
		send_messages(40);
		calm <= 1'b0;

		// pause the input until every character is out
		in_valid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		@(posedge clk);

		send_messages(120);
		in_valid <= 1'b0;

		// drain, then allow a few more cycles for strays
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_glyphs.size() != 0) begin
			fail_count++;
			$display("%0d characters never arrived", pending_glyphs.size());
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
bench/testbench.sv
